// ===== hdl/teoq_pkg.sv =====
`timescale 1ns / 1ps

package teoq_pkg;

  localparam int TIME_W   = 31;
  localparam int KIND_W   = 8;
  localparam int PAY_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Operation the datapath carries out in its apply cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_POP,
    OP_FULL,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    logic capture;  // latch the incoming beat and its compare vector
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sts_t;

endpackage

// ===== hdl/teoq_ctrl.sv =====
`timescale 1ns / 1ps

module teoq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_action,
  input  teoq_pkg::sts_t sts,
  output teoq_pkg::cmd_t cmd,
  output logic          busy
);
  import teoq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_APPLY;
          if (in_action == ACT_POP) begin
            op_nxt = sts.empty ? OP_EMPTY : OP_POP;
          end else begin
            op_nxt = sts.full ? OP_FULL : OP_INSERT;
          end
        end
      end
      S_APPLY: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign busy        = (state_r == S_APPLY);
  assign cmd.capture = accept;
  assign cmd.op      = (state_r == S_APPLY) ? op_r : OP_NONE;

`ifndef SYNTH
  a_apply_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> $past(accept))
    else $error("apply cycle without an accepted beat");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INSERT) |-> !sts.full)
    else $error("insert issued into a full agenda");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_POP) |-> !sts.empty)
    else $error("pop issued on an empty agenda");
`endif

endmodule

// ===== hdl/teoq_dp.sv =====
`timescale 1ns / 1ps

module teoq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  teoq_pkg::cmd_t                  cmd,
  input  logic [teoq_pkg::TIME_W-1:0]     in_time_stamp,
  input  logic [teoq_pkg::KIND_W-1:0]     in_event_kind,
  input  logic [teoq_pkg::PAY_W-1:0]      in_payload,
  output teoq_pkg::sts_t                  sts,
  output logic                            out_valid,
  output logic [teoq_pkg::STATUS_W-1:0]   out_status,
  output logic [teoq_pkg::TIME_W-1:0]     out_time_stamp,
  output logic [teoq_pkg::KIND_W-1:0]     out_event_kind,
  output logic [teoq_pkg::PAY_W-1:0]      out_payload,
  output logic                            out_now_empty
);
  import teoq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [TIME_W-1:0] times_r [DEPTH];
  logic [KIND_W-1:0] kinds_r [DEPTH];
  logic [PAY_W-1:0]  pays_r  [DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [TIME_W-1:0] t_r;
  logic [KIND_W-1:0] k_r;
  logic [PAY_W-1:0]  p_r;
  logic [DEPTH-1:0]  keep_r, keep_nxt, keep_prev;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [PAY_W-1:0]    out_pay_r;
  logic                out_empty_r;

  // A cell keeps its event when it is occupied and not later than the new one.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep_nxt[i] = (CNT_W'(i) < count_r) && (times_r[i] <= in_time_stamp);
    end
  end

  assign keep_prev = {keep_r[DEPTH-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r    <= in_time_stamp;
      k_r    <= in_event_kind;
      p_r    <= in_payload;
      keep_r <= keep_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [TIME_W-1:0] dn_time, up_time;
    logic [KIND_W-1:0] dn_kind, up_kind;
    logic [PAY_W-1:0]  dn_pay,  up_pay;

    if (g == 0) begin : g_first
      assign dn_time = t_r;
      assign dn_kind = k_r;
      assign dn_pay  = p_r;
    end else begin : g_mid
      assign dn_time = times_r[g-1];
      assign dn_kind = kinds_r[g-1];
      assign dn_pay  = pays_r[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign up_time = times_r[g];
      assign up_kind = kinds_r[g];
      assign up_pay  = pays_r[g];
    end else begin : g_body
      assign up_time = times_r[g+1];
      assign up_kind = kinds_r[g+1];
      assign up_pay  = pays_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.op == OP_INSERT && !keep_r[g]) begin
        if (g == 0 || keep_prev[g]) begin
          times_r[g] <= t_r;
          kinds_r[g] <= k_r;
          pays_r[g]  <= p_r;
        end else begin
          times_r[g] <= dn_time;
          kinds_r[g] <= dn_kind;
          pays_r[g]  <= dn_pay;
        end
      end else if (cmd.op == OP_POP) begin
        times_r[g] <= up_time;
        kinds_r[g] <= up_kind;
        pays_r[g]  <= up_pay;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      OP_INSERT: count_nxt = count_r + CNT_W'(1);
      OP_POP:    count_nxt = count_r - CNT_W'(1);
      default:   count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= (cmd.op != OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      out_status_r <= (cmd.op == OP_FULL)  ? ST_FULL :
                      (cmd.op == OP_EMPTY) ? ST_EMPTY : ST_DONE;
      out_time_r   <= (cmd.op == OP_POP) ? times_r[0] : '0;
      out_kind_r   <= (cmd.op == OP_POP) ? kinds_r[0] : '0;
      out_pay_r    <= (cmd.op == OP_POP) ? pays_r[0]  : '0;
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign sts.full  = (count_r == CNT_W'(DEPTH));
  assign sts.empty = (count_r == '0);

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_time_stamp = out_time_r;
  assign out_event_kind = out_kind_r;
  assign out_payload    = out_pay_r;
  assign out_now_empty  = out_empty_r;

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  for (genvar a = 0; a < DEPTH - 1; a++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (CNT_W'(a + 1) < count_r) |-> (times_r[a] <= times_r[a+1]))
      else $error("stored events out of timestamp order");
  end
`endif

endmodule

// ===== hdl/timestamp_ordered_event_queue.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                                  Handshake
// input     in_{action,time_stamp,event_kind,payload}              start high, busy low
// result    out_{status,time_stamp,event_kind,payload,now_empty}   out_valid, one cycle
//
// For each beat, the accept edge registers the new timestamp compared
// against every stored cell, and the next edge shifts the cells and
// registers the result. busy is high for that one apply cycle.
// The result shows on the out_ ports the cycle after the apply edge; the
// next beat can be accepted at the edge that ends that cycle. The receiver
// cannot stall.
// rst_n is synchronous, active low: it empties the agenda and the strobe.
module timestamp_ordered_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_action,
  input  logic [teoq_pkg::TIME_W-1:0]     in_time_stamp,
  input  logic [teoq_pkg::KIND_W-1:0]     in_event_kind,
  input  logic [teoq_pkg::PAY_W-1:0]      in_payload,
  output logic                            out_valid,
  output logic [teoq_pkg::STATUS_W-1:0]   out_status,
  output logic [teoq_pkg::TIME_W-1:0]     out_time_stamp,
  output logic [teoq_pkg::KIND_W-1:0]     out_event_kind,
  output logic [teoq_pkg::PAY_W-1:0]      out_payload,
  output logic                            out_now_empty
);
  import teoq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: decide insert, pop or reject from the fill state, sequence
  // the apply cycle.
  teoq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Datapath: a row of cells kept in timestamp order; insert opens a gap
  // behind the last cell not later than the new event, pop shifts toward
  // the head.
  teoq_dp #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_time_stamp  (in_time_stamp),
    .in_event_kind  (in_event_kind),
    .in_payload     (in_payload),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_time_stamp (out_time_stamp),
    .out_event_kind (out_event_kind),
    .out_payload    (out_payload),
    .out_now_empty  (out_now_empty)
  );

endmodule
